@@ design/sdcd_pkg.sv @@
`timescale 1ns / 1ps

package sdcd_pkg;

  // Width of the shared divider: the largest PLL rate, 24 MHz times 32, fits in 30 bits.
  localparam int QW = 30;
  localparam int CW = $clog2(QW);

  localparam int TW = 28;
  localparam int MULW = 5;
  localparam int DIVW = 2;
  localparam int CFGW = 5;

  localparam logic [QW-1:0] OSC_HZ = QW'(24000000);
  localparam logic [TW-1:0] OSC_TGT_HZ = TW'(24000000);
  localparam logic [TW-1:0] BAND_SLOW_HZ = TW'(400000);
  localparam logic [TW-1:0] BAND_SD_HZ = TW'(25000000);
  localparam logic [TW-1:0] BAND_HS_HZ = TW'(52000000);

  localparam logic [QW-1:0] MAX_DIVIDER = QW'(16);
  localparam logic [1:0] MAX_PRESCALE = 2'd3;

  localparam logic CFG_PLL_MUL = 1'b0;
  localparam logic CFG_PLL_DIV = 1'b1;

  typedef logic [TW-1:0] target_t;
  typedef logic [QW-1:0] quot_t;

endpackage

@@ design/sdcd_in_if.sv @@
`timescale 1ns / 1ps

interface sdcd_in_if;
  logic valid;
  logic ready;
  logic [sdcd_pkg::TW-1:0] target_hz;

  modport source (output valid, output target_hz, input ready);
  modport sink (input valid, input target_hz, output ready);
endinterface

@@ design/sdcd_out_if.sv @@
`timescale 1ns / 1ps

interface sdcd_out_if;
  logic valid;
  logic ready;
  logic [31:0] clock_word;
  logic valid_res;

  modport source (output valid, output clock_word, output valid_res, input ready);
  modport sink (input valid, input clock_word, input valid_res, output ready);
endinterface

@@ design/sdcd_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module sdcd_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  sdcd_pkg::quot_t      dividend,
  input  sdcd_pkg::quot_t      divisor,
  output logic                 done,
  output sdcd_pkg::quot_t      quotient,
  output sdcd_pkg::quot_t      remainder
);

  sdcd_pkg::quot_t q_r, q_nxt;
  sdcd_pkg::quot_t rem_r, rem_nxt;
  sdcd_pkg::quot_t dvs_r;
  logic [sdcd_pkg::CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [sdcd_pkg::QW:0] trial;
  logic [sdcd_pkg::QW:0] diff;
  logic ge;

  always_comb begin
    trial = {rem_r, q_r[sdcd_pkg::QW-1]};
    diff = trial - {1'b0, dvs_r};
    ge = (trial >= {1'b0, dvs_r});
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = {q_r[sdcd_pkg::QW-2:0], ge};
      rem_nxt = ge ? diff[sdcd_pkg::QW-1:0] : trial[sdcd_pkg::QW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == sdcd_pkg::CW'(sdcd_pkg::QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done = done_r;
  assign quotient = q_r;
  assign remainder = rem_r;

endmodule

@@ design/sd_clock_divider_config_core.sv @@
`timescale 1ns / 1ps
// A request at or below 24 MHz needs one division and a PLL request needs two; every nonzero
// request then passes zero to three halvings, and a zero request goes straight to the result.
// The 30-step serial divider is shared: it runs for the PLL rate on PLL requests only and
// for the divider on every nonzero request. One item is in work at a time and the next is
// taken in the cycle after the result is loaded, which waits until the output is free.
// Synchronous active-low reset clears the sequencer, the output valid and both config registers.
module sd_clock_divider_config_core (
  input  logic                        clk,
  input  logic                        rst_n,
  sdcd_in_if.sink                     in_ch,
  sdcd_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [sdcd_pkg::CFGW-1:0]   cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PLL   = 3'd1;
  localparam logic [2:0] S_PWAIT = 3'd2;
  localparam logic [2:0] S_TDIV  = 3'd3;
  localparam logic [2:0] S_TWAIT = 3'd4;
  localparam logic [2:0] S_HALVE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [sdcd_pkg::MULW-1:0] mul_r;
  logic [sdcd_pkg::DIVW-1:0] div_r;
  sdcd_pkg::target_t target_r, target_nxt;
  sdcd_pkg::quot_t src_r, src_nxt;
  sdcd_pkg::quot_t d_r, d_nxt;
  logic [1:0] pre_r, pre_nxt;
  logic pll_sel_r, pll_sel_nxt;
  logic fail_r, fail_nxt;
  logic [31:0] word_r, word_nxt;
  logic vres_r, vres_nxt;
  logic ovalid_r, ovalid_nxt;

  logic div_start;
  sdcd_pkg::quot_t div_a, div_b, div_q, div_rem;
  logic div_done;
  logic [sdcd_pkg::QW:0] d_inc;
  logic [2:0] outph, samph;
  logic in_acc, out_free;

  sdcd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_free = !ovalid_r || out_ch.ready;

  always_comb begin
    if (target_r <= sdcd_pkg::BAND_SLOW_HZ) begin
      outph = 3'd0; samph = 3'd0;
    end else if (target_r <= sdcd_pkg::BAND_SD_HZ) begin
      outph = 3'd0; samph = 3'd5;
    end else if (target_r <= sdcd_pkg::BAND_HS_HZ) begin
      outph = 3'd3; samph = 3'd4;
    end else begin
      outph = 3'd1; samph = 3'd4;
    end
  end

  always_comb begin
    state_nxt = state_r;
    target_nxt = target_r;
    src_nxt = src_r;
    d_nxt = d_r;
    pre_nxt = pre_r;
    pll_sel_nxt = pll_sel_r;
    fail_nxt = fail_r;
    word_nxt = word_r;
    vres_nxt = vres_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    div_start = 1'b0;
    div_a = src_r;
    div_b = sdcd_pkg::QW'(target_r);
    d_inc = {1'b0, d_r} + 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          target_nxt = in_ch.target_hz;
          pre_nxt = '0;
          fail_nxt = (in_ch.target_hz == '0);
          pll_sel_nxt = (in_ch.target_hz > sdcd_pkg::OSC_TGT_HZ);
          src_nxt = sdcd_pkg::OSC_HZ;
          if (in_ch.target_hz == '0) begin
            state_nxt = S_DONE;
          end else if (in_ch.target_hz > sdcd_pkg::OSC_TGT_HZ) begin
            state_nxt = S_PLL;
          end else begin
            state_nxt = S_TDIV;
          end
        end
      end
      S_PLL: begin
        div_start = 1'b1;
        div_a = sdcd_pkg::OSC_HZ * sdcd_pkg::QW'({1'b0, mul_r} + 6'd1);
        div_b = sdcd_pkg::QW'({1'b0, div_r} + 3'd1);
        state_nxt = S_PWAIT;
      end
      S_PWAIT: begin
        if (div_done) begin
          src_nxt = div_q;
          state_nxt = S_TDIV;
        end
      end
      S_TDIV: begin
        div_start = 1'b1;
        state_nxt = S_TWAIT;
      end
      S_TWAIT: begin
        if (div_done) begin
          d_nxt = div_q + sdcd_pkg::QW'(div_rem != '0);
          state_nxt = S_HALVE;
        end
      end
      S_HALVE: begin
        if (d_r > sdcd_pkg::MAX_DIVIDER) begin
          if (pre_r == sdcd_pkg::MAX_PRESCALE) begin
            fail_nxt = 1'b1;
            state_nxt = S_DONE;
          end else begin
            pre_nxt = pre_r + 1'b1;
            d_nxt = d_inc[sdcd_pkg::QW:1];
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          vres_nxt = !fail_r;
          if (fail_r) begin
            word_nxt = '0;
          end else begin
            word_nxt = {1'b1, 6'b0, pll_sel_r, 1'b0, samph, 2'b0, pre_r, 5'b0, outph,
                        4'b0, d_r[3:0] - 4'd1};
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
      mul_r <= '0;
      div_r <= '0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) begin
        if (cfg_index == sdcd_pkg::CFG_PLL_MUL) begin
          mul_r <= cfg_data[sdcd_pkg::MULW-1:0];
        end else begin
          div_r <= cfg_data[sdcd_pkg::DIVW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    target_r <= target_nxt;
    src_r <= src_nxt;
    d_r <= d_nxt;
    pre_r <= pre_nxt;
    pll_sel_r <= pll_sel_nxt;
    fail_r <= fail_nxt;
    word_r <= word_nxt;
    vres_r <= vres_nxt;
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.clock_word = word_r;
  assign out_ch.valid_res = vres_r;

  // A valid result always carries the enable bit; a failed one is all zeros.
  a_word_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.valid_res ? out_ch.clock_word[31] : (out_ch.clock_word == '0)))
    else $error("clock word does not match its valid flag");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_PWAIT || state_r == S_TWAIT))
    else $error("divider finished outside a wait state");

  // A successful item leaves the halving loop with a divider from 1 to 16.
  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !fail_r) |-> (d_r != '0 && d_r <= sdcd_pkg::MAX_DIVIDER))
    else $error("divider out of range at result");

  // Once an item is taken the block is busy in the cycle after it.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input ready right after an accepted item");

endmodule
